[src/uitp_pkg.sv]
// ----------------------------------------------------------------------------
// uitp_pkg
// Types and constants shared by the unsigned integer text parser.
// ----------------------------------------------------------------------------
package uitp_pkg;

	localparam int COUNT_BITS = 16;
	localparam int OUT_COUNT_BITS = 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [31:0] DEC_LIMIT = 32'd429496729;
	localparam logic [3:0] DEC_LAST = 4'd5;
	localparam logic [31:0] HEX_LIMIT = 32'h0FFF_FFFF;

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_FIRST = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Parser state carried between characters of one string
	typedef struct packed {
		logic [31:0] accumulator;
		logic [COUNT_BITS-1:0] char_index;
		logic stopped;
		status_t latched_status;
		logic hex_mode;
		logic [COUNT_BITS-1:0] overflow_index;
	} pstate_t;

	typedef struct packed {
		status_t status;
		logic [31:0] value;
		logic [OUT_COUNT_BITS-1:0] consumed;
		logic [OUT_COUNT_BITS-1:0] error_position;
	} result_t;

endpackage

[src/uitp_step.sv]
// ----------------------------------------------------------------------------
// uitp_step
// Combinational update of the parser state for one character or end request.
// ----------------------------------------------------------------------------
module uitp_step (
	input  uitp_pkg::pstate_t cur,
	input  logic              kind,
	input  logic [7:0]        char_code,
	input  logic              is_end,
	output uitp_pkg::pstate_t nxt,
	output uitp_pkg::result_t res
);
	import uitp_pkg::*;

	logic first;
	logic hex;
	logic dig_ok;
	logic [3:0] dig;
	logic ovf;
	logic [31:0] acc_dec;
	logic [31:0] acc_hex;
	status_t st_end;
	logic [COUNT_BITS+OUT_COUNT_BITS-1:0] idx_ext;
	logic [COUNT_BITS+OUT_COUNT_BITS-1:0] ovf_ext;

	assign first = !cur.stopped && (cur.char_index == '0);
	assign hex = first ? kind : cur.hex_mode;

	always_comb begin
		dig_ok = 1'b0;
		dig = 4'd0;
		if (char_code >= CH_0 && char_code <= CH_9) begin
			dig_ok = 1'b1;
			dig = 4'(char_code - CH_0);
		end else if (hex && char_code >= CH_UA && char_code <= CH_UF) begin
			dig_ok = 1'b1;
			dig = 4'(char_code - CH_UA + 8'd10);
		end else if (hex && char_code >= CH_LA && char_code <= CH_LF) begin
			dig_ok = 1'b1;
			dig = 4'(char_code - CH_LA + 8'd10);
		end
	end

	// x10 as shift-and-add; the overflow check guarantees no wrap when used
	assign acc_dec = (cur.accumulator << 3) + (cur.accumulator << 1) + 32'(dig);
	assign acc_hex = {cur.accumulator[27:0], dig};

	assign ovf = hex ? (cur.accumulator > HEX_LIMIT)
		: ((cur.accumulator > DEC_LIMIT) || (cur.accumulator == DEC_LIMIT && dig > DEC_LAST));

	always_comb begin
		nxt = cur;
		if (is_end) begin
			nxt = '0;
		end else if (!cur.stopped) begin
			nxt.hex_mode = hex;
			if (!dig_ok) begin
				nxt.stopped = 1'b1;
				nxt.latched_status = first ? ST_BAD_FIRST : ST_OK;
			end else if (ovf) begin
				nxt.stopped = 1'b1;
				nxt.latched_status = ST_OVERFLOW;
				nxt.overflow_index = cur.char_index;
			end else begin
				nxt.accumulator = hex ? acc_hex : acc_dec;
				if (cur.char_index != COUNT_MAX)
					nxt.char_index = cur.char_index + 1'b1;
			end
		end
	end

	assign st_end = first ? ST_EMPTY : cur.latched_status;
	assign idx_ext = {{OUT_COUNT_BITS{1'b0}}, cur.char_index};
	assign ovf_ext = {{OUT_COUNT_BITS{1'b0}}, cur.overflow_index};

	always_comb begin
		res.status = st_end;
		res.value = (st_end == ST_OK) ? cur.accumulator : '0;
		res.consumed = (st_end == ST_OK) ? idx_ext[OUT_COUNT_BITS-1:0] : '0;
		res.error_position = (st_end == ST_OVERFLOW) ? ovf_ext[OUT_COUNT_BITS-1:0] : '0;
	end

endmodule

[src/unsigned_integer_text_parser_core.sv]
// ----------------------------------------------------------------------------
// unsigned_integer_text_parser_core
// Parses a decimal or hex character stream into a 32-bit unsigned value.
// ----------------------------------------------------------------------------
// Input stream: one character per request in s_tdata, radix in s_tuser
// (taken from the first request of a string), s_tlast marks the end request,
// which carries no character. Each string produces exactly one result on the
// output stream, on its end request: status in m_tuser, value, digit count
// and overflow position in m_tdata.
// A request is first held in the input register; the result of an end request
// is then registered in the output register, which drives m_tvalid.
// Throughput: one request per cycle while s_tready is high, set by the
// combinational multiply-and-compare between input register and parser state.
// When the receiver stalls, the result is held in the output register and
// character requests keep flowing, as they produce no result, until the next
// end request reaches the input register; it waits there and s_tready drops.
// Reset clears the parser state and both valid flags; the first request
// after reset starts a new string.
// ----------------------------------------------------------------------------
module unsigned_integer_text_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tuser,   // [0] kind
	input  logic        s_tlast,   // is_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] value, [47:32] consumed, [63:48] error_position
	output logic [1:0]  m_tuser    // [1:0] status
);
	import uitp_pkg::*;

	logic valid_s1;
	logic kind_s1;
	logic [7:0] char_s1;
	logic end_s1;

	pstate_t st_q;
	pstate_t st_nxt;
	result_t res;
	result_t res_q;
	logic out_valid_q;
	logic advance;

	assign advance = valid_s1 && (!end_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			char_s1 <= s_tdata;
			end_s1 <= s_tlast;
		end
	end

	uitp_step u_step (
		.cur       (st_q),
		.kind      (kind_s1),
		.char_code (char_s1),
		.is_end    (end_s1),
		.nxt       (st_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = res_q.status;
	assign m_tdata = {res_q.error_position, res_q.consumed, res_q.value};

	// A held result never carries fields that its status rules out
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status != ST_OK |-> res_q.value == '0 && res_q.consumed == '0)
		else $error("non-ok result with nonzero value or count");

	a_pos_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status != ST_OVERFLOW |-> res_q.error_position == '0)
		else $error("error position set without overflow");

	// Empty string is only decided at the end request, never latched
	a_no_empty_latch: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.latched_status != ST_EMPTY)
		else $error("empty status latched in parser state");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && end_s1 |=> st_q.char_index == '0 && !st_q.stopped && m_tvalid)
		else $error("end request did not clear state or post a result");

	a_stopped_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !end_s1 && st_q.stopped |=> $stable(st_q))
		else $error("state changed after parsing stopped");

endmodule
